// File: src/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Shared constants, codes and types of the generational handle table.
// ----------------------------------------------------------------------------
`default_nettype none
package ght_pkg;

  localparam int SLOTS_DEF    = 1024;
  localparam int GEN_BITS_DEF = 16;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int SERIAL_W     = 32;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MARK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DENSE,
    S_MOVE,
    S_DONE
  } ght_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic dense;
    logic move;
    logic finish;
  } ght_cmd_t;

  typedef struct packed {
    logic need_dense;
    logic need_move;
  } ght_sts_t;

endpackage
`default_nettype wire

// File: src/ght_if.sv
// ----------------------------------------------------------------------------
// ght_if
// Request and result channels of the generational handle table.
// ----------------------------------------------------------------------------
`default_nettype none
interface ght_in_if #(
  parameter int SLOTS    = ght_pkg::SLOTS_DEF,
  parameter int GEN_BITS = ght_pkg::GEN_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [ght_pkg::MODE_W-1:0]   mode;
  logic [$clog2(SLOTS)-1:0]     slot;
  logic [GEN_BITS-1:0]          generation;

  modport source (output valid, mode, slot, generation, input ready);
  modport sink   (input valid, mode, slot, generation, output ready);
endinterface

interface ght_out_if #(
  parameter int SLOTS    = ght_pkg::SLOTS_DEF,
  parameter int GEN_BITS = ght_pkg::GEN_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [ght_pkg::STATUS_W-1:0] status;
  logic                         alive;
  logic [$clog2(SLOTS)-1:0]     out_slot;
  logic [GEN_BITS-1:0]          out_generation;
  logic [$clog2(SLOTS)-1:0]     dense_index;
  logic                         moved;
  logic [$clog2(SLOTS)-1:0]     moved_from;
  logic                         dirty_bit;
  logic [$clog2(SLOTS+1)-1:0]   live_count;
  logic [ght_pkg::SERIAL_W-1:0] mutation_count;

  modport source (output valid, status, alive, out_slot, out_generation, dense_index,
                  moved, moved_from, dirty_bit, live_count, mutation_count,
                  input ready);
  modport sink   (input valid, status, alive, out_slot, out_generation, dense_index,
                  moved, moved_from, dirty_bit, live_count, mutation_count,
                  output ready);
endinterface
`default_nettype wire

// File: src/generational_handle_table.sv
// Steps: accept, execute and done for allocate, mark dirty and rejected
// requests; a free that moves an entry adds a move step, and a live check
// alive or lookup adds a dense read step, set by the dependent synchronous
// memory reads. Throughput: one request at a time.
// Reset: no clearing pass; never-used slots are tracked by a high-water mark.
// ----------------------------------------------------------------------------
// generational_handle_table
// Fixed-size slot map with generational handles, a LIFO free list and a
// dense array compacted by swap-remove on free.
// ----------------------------------------------------------------------------
`default_nettype none
module generational_handle_table #(
  parameter int SLOTS    = ght_pkg::SLOTS_DEF,
  parameter int GEN_BITS = ght_pkg::GEN_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ght_in_if.sink    in_ch,
  ght_out_if.source out_ch
);
  import ght_pkg::*;

  ght_cmd_t cmd;
  ght_sts_t sts;

  ght_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  ght_datapath #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_mode(in_ch.mode), .in_slot(in_ch.slot), .in_generation(in_ch.generation),
    .status_r(out_ch.status), .alive_r(out_ch.alive), .out_slot_r(out_ch.out_slot),
    .out_generation_r(out_ch.out_generation), .dense_index_r(out_ch.dense_index),
    .moved_r(out_ch.moved), .moved_from_r(out_ch.moved_from),
    .dirty_bit_r(out_ch.dirty_bit), .live_count_r(out_ch.live_count),
    .mutation_count_r(out_ch.mutation_count)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while a request is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.live_count <= ($clog2(SLOTS+1))'(SLOTS)))
    else $error("live count exceeds table size");

  a_move_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.moved) |-> (out_ch.dirty_bit && out_ch.status == STATUS_OK))
    else $error("moved entry not reported dirty");

  a_alloc_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STATUS_OK && out_ch.alive && out_ch.out_generation != '0)
    |-> out_ch.dirty_bit)
    else $error("new handle entry not dirty");
endmodule
`default_nettype wire

// File: src/ght_ram.sv
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// Sequencer: steps one request through lookup, dependent reads and result.
// ----------------------------------------------------------------------------
`default_nettype none
module ght_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ght_pkg::ght_sts_t sts,
  output ght_pkg::ght_cmd_t      cmd
);
  import ght_pkg::*;

  ght_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_move) begin
          state_nxt = S_MOVE;
        end else if (sts.need_dense) begin
          state_nxt = S_DENSE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DENSE: begin
        cmd.dense = 1'b1;
        state_nxt = S_DONE;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.finish | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// File: src/ght_datapath.sv
// ----------------------------------------------------------------------------
// ght_datapath
// Slot and dense memories, free list head, counters and result registers.
// Slots at or above the high-water mark have never been handed out and read
// as initial values: link to the next slot, generation zero, not live.
// ----------------------------------------------------------------------------
`default_nettype none
module ght_datapath #(
  parameter int SLOTS    = ght_pkg::SLOTS_DEF,
  parameter int GEN_BITS = ght_pkg::GEN_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ght_pkg::ght_cmd_t            cmd,
  output ght_pkg::ght_sts_t                 sts,
  input  wire logic [ght_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [$clog2(SLOTS)-1:0]     in_slot,
  input  wire logic [GEN_BITS-1:0]          in_generation,
  output logic      [ght_pkg::STATUS_W-1:0] status_r,
  output logic                              alive_r,
  output logic      [$clog2(SLOTS)-1:0]     out_slot_r,
  output logic      [GEN_BITS-1:0]          out_generation_r,
  output logic      [$clog2(SLOTS)-1:0]     dense_index_r,
  output logic                              moved_r,
  output logic      [$clog2(SLOTS)-1:0]     moved_from_r,
  output logic                              dirty_bit_r,
  output logic      [$clog2(SLOTS+1)-1:0]   live_count_r,
  output logic      [ght_pkg::SERIAL_W-1:0] mutation_count_r
);
  import ght_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int GW = GEN_BITS;
  localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);

  logic [MODE_W-1:0]   mode_r;
  logic [SW-1:0]       slot_r;
  logic [GW-1:0]       gen_r;
  logic [LW-1:0]       head_r, count_r, hw_r;
  logic [SERIAL_W-1:0] serial_r;
  logic [SW-1:0]       hole_r;

  logic [STATUS_W-1:0] res_status_r;
  logic                res_alive_r, res_moved_r, res_dbit_r;
  logic [SW-1:0]       res_oslot_r, res_dix_r, res_mfrom_r;
  logic [GW-1:0]       res_ogen_r;

  logic [LW-1:0] link_rd;
  logic [GW-1:0] gen_rd;
  logic          live_rd;
  logic          dirty_rd;
  logic [SW-1:0] d2s_rd;

  logic          link_we, gen_we, live_we, d2s_we, dirty_we;
  logic [SW-1:0] link_waddr, live_waddr, d2s_waddr, dirty_waddr;
  logic [LW-1:0] link_wdata;
  logic [SW-1:0] d2s_wdata;
  logic          live_wdata, dirty_wdata;
  logic [SW-1:0] slot_raddr;

  logic [LW-1:0] addr_q, rlink, last;
  logic [GW-1:0] rgen, newgen;
  logic          touched, rlive, hdl_ok, full, moved_w, ls_ok;
  logic          is_alloc, is_free, is_mark;
  logic          alloc_ok, free_ok, mark_ok;
  logic [SW-1:0] dix;

  assign slot_raddr = (in_mode == MODE_ALLOC) ? head_r[SW-1:0] : in_slot;

  ght_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(slot_raddr), .rdata_r(link_rd)
  );
  ght_ram #(.WIDTH(GW), .DEPTH(SLOTS)) u_gen (
    .clk, .we(gen_we), .waddr(head_r[SW-1:0]), .wdata(newgen),
    .raddr(slot_raddr), .rdata_r(gen_rd)
  );
  ght_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_live (
    .clk, .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
    .raddr(slot_raddr), .rdata_r(live_rd)
  );
  ght_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_d2s (
    .clk, .we(d2s_we), .waddr(d2s_waddr), .wdata(d2s_wdata),
    .raddr(last[SW-1:0]), .rdata_r(d2s_rd)
  );
  ght_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_dirty (
    .clk, .we(dirty_we), .waddr(dirty_waddr), .wdata(dirty_wdata),
    .raddr(dix), .rdata_r(dirty_rd)
  );

  always_comb begin
    is_alloc = (mode_r == MODE_ALLOC);
    is_free  = (mode_r == MODE_FREE);
    is_mark  = (mode_r == MODE_MARK);
    addr_q   = is_alloc ? head_r : LW'(slot_r);
    touched  = addr_q < hw_r;
    rlink    = touched ? link_rd : addr_q + LW'(1);
    rgen     = touched ? gen_rd : '0;
    rlive    = touched & live_rd;
    dix      = rlink[SW-1:0];
    last     = count_r - LW'(1);
    hdl_ok   = (LW'(slot_r) < SLOTS_L) && (gen_r != '0) && rlive && (rgen == gen_r)
               && (rlink < count_r) && (count_r <= SLOTS_L);
    full     = (head_r >= SLOTS_L) || (count_r >= SLOTS_L);
    newgen   = rgen + GW'(1);
    if (newgen == '0) begin
      newgen = GW'(1);
    end
    moved_w  = rlink != last;
    alloc_ok = cmd.exec & is_alloc & ~full;
    free_ok  = cmd.exec & is_free & hdl_ok;
    mark_ok  = cmd.exec & is_mark & hdl_ok;
    ls_ok    = LW'(d2s_rd) < SLOTS_L;

    sts.need_move  = is_free & hdl_ok & moved_w;
    sts.need_dense = ((mode_r == MODE_CHECK) || (mode_r == MODE_LOOKUP)) & hdl_ok;

    gen_we      = alloc_ok;
    live_we     = alloc_ok | free_ok;
    live_waddr  = is_alloc ? head_r[SW-1:0] : slot_r;
    live_wdata  = is_alloc;

    link_we     = alloc_ok | free_ok | (cmd.move & ls_ok);
    link_waddr  = cmd.move ? d2s_rd : (is_alloc ? head_r[SW-1:0] : slot_r);
    link_wdata  = cmd.move ? LW'(hole_r) : (is_alloc ? count_r : head_r);

    d2s_we      = alloc_ok | cmd.move;
    d2s_waddr   = cmd.move ? hole_r : count_r[SW-1:0];
    d2s_wdata   = cmd.move ? d2s_rd : head_r[SW-1:0];

    dirty_we    = alloc_ok | free_ok | mark_ok | cmd.move;
    dirty_waddr = cmd.move ? hole_r : (is_alloc ? count_r[SW-1:0] :
                  (is_free ? last[SW-1:0] : dix));
    dirty_wdata = cmd.move | is_alloc | is_mark;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      hw_r     <= '0;
      serial_r <= SERIAL_W'(1);
    end else if (alloc_ok) begin
      head_r   <= rlink;
      count_r  <= count_r + LW'(1);
      serial_r <= serial_r + SERIAL_W'(1);
      if (!touched) begin
        hw_r <= hw_r + LW'(1);
      end
    end else if (free_ok) begin
      head_r   <= LW'(slot_r);
      count_r  <= last;
      serial_r <= serial_r + SERIAL_W'(1);
    end else if (mark_ok) begin
      serial_r <= serial_r + SERIAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      slot_r <= in_slot;
      gen_r  <= in_generation;
    end
    if (cmd.exec) begin
      hole_r       <= dix;
      res_status_r <= STATUS_STALE;
      res_alive_r  <= 1'b0;
      res_oslot_r  <= '0;
      res_ogen_r   <= '0;
      res_dix_r    <= '0;
      res_moved_r  <= 1'b0;
      res_mfrom_r  <= '0;
      res_dbit_r   <= 1'b0;
      case (mode_r)
        MODE_ALLOC: begin
          if (full) begin
            res_status_r <= STATUS_FULL;
          end else begin
            res_status_r <= STATUS_OK;
            res_alive_r  <= 1'b1;
            res_oslot_r  <= head_r[SW-1:0];
            res_ogen_r   <= newgen;
            res_dix_r    <= count_r[SW-1:0];
            res_dbit_r   <= 1'b1;
          end
        end
        MODE_FREE: begin
          if (hdl_ok) begin
            res_status_r <= STATUS_OK;
            res_dix_r    <= dix;
            res_moved_r  <= moved_w;
            res_mfrom_r  <= moved_w ? last[SW-1:0] : '0;
            res_dbit_r   <= moved_w;
          end
        end
        MODE_CHECK: begin
          res_status_r <= STATUS_OK;
          if (hdl_ok) begin
            res_alive_r <= 1'b1;
            res_dix_r   <= dix;
          end
        end
        MODE_MARK: begin
          if (hdl_ok) begin
            res_status_r <= STATUS_OK;
            res_alive_r  <= 1'b1;
            res_dix_r    <= dix;
            res_dbit_r   <= 1'b1;
          end
        end
        MODE_LOOKUP: begin
          if (hdl_ok) begin
            res_status_r <= STATUS_OK;
            res_alive_r  <= 1'b1;
            res_dix_r    <= dix;
          end
        end
        default: begin
          res_status_r <= STATUS_STALE;
        end
      endcase
    end
    if (cmd.dense) begin
      res_dbit_r <= dirty_rd;
    end
    if (cmd.finish) begin
      status_r         <= res_status_r;
      alive_r          <= res_alive_r;
      out_slot_r       <= res_oslot_r;
      out_generation_r <= res_ogen_r;
      dense_index_r    <= res_dix_r;
      moved_r          <= res_moved_r;
      moved_from_r     <= res_mfrom_r;
      dirty_bit_r      <= res_dbit_r;
      live_count_r     <= count_r;
      mutation_count_r <= serial_r;
    end
  end
endmodule
`default_nettype wire

// File: tb/generational_handle_table_tb.sv
// ----------------------------------------------------------------------------
// generational_handle_table_tb
// Self-checking testbench of the generational handle table. A behavioral
// slot map predicts every result beat, and the results are compared field by
// field. Directed tests cover the extremes of the handle fields, every mode,
// stale handles and repeated reuse of one slot. Random tests follow, mostly
// with handles that are live or recently freed, and with random stalls on both
// sides except in a calm stretch in the middle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_table_tb;
  import ght_pkg::*;

  localparam int NSLOT = SLOTS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                alive;
    logic [9:0]          slot;
    logic [15:0]         gen;
    logic [9:0]          dix;
    logic                moved;
    logic [9:0]          mfrom;
    logic                dbit;
    logic [10:0]         count;
    logic [31:0]         serial;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  ght_in_if  in_ch ();
  ght_out_if out_ch ();

  generational_handle_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Shadow state of the slot map.
  logic [10:0] link_m [NSLOT];
  logic [15:0] gen_m [NSLOT];
  logic        live_m [NSLOT];
  logic [9:0]  dslot_m [NSLOT];
  logic        dirty_m [NSLOT];
  logic [10:0] head_m;
  logic [10:0] count_m;
  logic [31:0] serial_m;

  table_result_t pending_results[$];
  int errors = 0;
  bit calm = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic bit is_live(input logic [9:0] s, input logic [15:0] g);
    if (g == 0 || !live_m[s] || gen_m[s] != g) return 1'b0;
    return link_m[s] < count_m;
  endfunction

  function automatic table_result_t apply_request(input logic [2:0] mode,
                                                  input logic [9:0] s,
                                                  input logic [15:0] g);
    table_result_t r;
    logic [15:0] ng;
    logic [10:0] hole, last;
    logic [9:0] ls;
    r = '0;
    if (mode == MODE_ALLOC) begin
      if (head_m >= NSLOT || count_m >= NSLOT) begin
        r.status = STATUS_FULL;
      end else begin
        ng = gen_m[head_m] + 16'd1;
        if (ng == 0) ng = 16'd1;
        r.slot = head_m[9:0];
        gen_m[r.slot] = ng;
        live_m[r.slot] = 1'b1;
        head_m = link_m[r.slot];
        link_m[r.slot] = count_m;
        dslot_m[count_m] = r.slot;
        dirty_m[count_m] = 1'b1;
        r.dix = count_m[9:0];
        count_m++;
        serial_m++;
        r.alive = 1'b1;
        r.gen = ng;
        r.dbit = 1'b1;
      end
    end else if (mode == MODE_FREE) begin
      if (!is_live(s, g)) begin
        r.status = STATUS_STALE;
      end else begin
        hole = link_m[s];
        last = count_m - 11'd1;
        if (hole != last) begin
          ls = dslot_m[last];
          dslot_m[hole] = ls;
          link_m[ls] = hole;
          dirty_m[hole] = 1'b1;
          r.moved = 1'b1;
          r.mfrom = last[9:0];
        end
        dirty_m[last] = 1'b0;
        count_m = last;
        link_m[s] = head_m;
        head_m = {1'b0, s};
        live_m[s] = 1'b0;
        serial_m++;
        r.dix = hole[9:0];
        r.dbit = dirty_m[hole];
      end
    end else if (mode == MODE_CHECK || mode == MODE_MARK || mode == MODE_LOOKUP) begin
      if (!is_live(s, g)) begin
        r.status = (mode == MODE_CHECK) ? STATUS_OK : STATUS_STALE;
      end else begin
        if (mode == MODE_MARK) begin
          dirty_m[link_m[s]] = 1'b1;
          serial_m++;
        end
        r.alive = 1'b1;
        r.dix = link_m[s][9:0];
        r.dbit = dirty_m[link_m[s]];
      end
    end else begin
      r.status = STATUS_STALE;
    end
    r.count = count_m;
    r.serial = serial_m;
    return r;
  endfunction

  task automatic send(input logic [2:0] mode, input logic [9:0] s, input logic [15:0] g);
    while (!calm && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.slot       <= s;
    in_ch.generation <= g;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(apply_request(mode, s, g));
  endtask

  always @(posedge clk) begin
    table_result_t w;
    if (rst_n) begin
      out_ch.ready <= calm || ($urandom_range(99) >= 7);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          w = pending_results.pop_front();
          if (out_ch.status != w.status) report("status", out_ch.status, w.status);
          if (out_ch.alive != w.alive) report("alive", out_ch.alive, w.alive);
          if (out_ch.out_slot != w.slot) report("out_slot", out_ch.out_slot, w.slot);
          if (out_ch.out_generation != w.gen)
            report("out_generation", out_ch.out_generation, w.gen);
          if (out_ch.dense_index != w.dix) report("dense_index", out_ch.dense_index, w.dix);
          if (out_ch.moved != w.moved) report("moved", out_ch.moved, w.moved);
          if (out_ch.moved_from != w.mfrom) report("moved_from", out_ch.moved_from, w.mfrom);
          if (out_ch.dirty_bit != w.dbit) report("dirty_bit", out_ch.dirty_bit, w.dbit);
          if (out_ch.live_count != w.count) report("live_count", out_ch.live_count, w.count);
          if (out_ch.mutation_count != w.serial)
            report("mutation_count", out_ch.mutation_count, w.serial);
        end
      end
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  // Picks a handle that is live, or recently freed, or random noise.
  task automatic pick_handle(output logic [9:0] s, output logic [15:0] g);
    int k;
    k = $urandom_range(99);
    s = 10'($urandom_range(NSLOT - 1));
    g = 16'($urandom);
    if (k < 60 && count_m > 0) begin
      s = dslot_m[$urandom_range(count_m - 1)];
      g = gen_m[s];
    end else if (k < 85) begin
      s = 10'($urandom_range(31));
      g = gen_m[s] + (k % 3 == 0 ? 16'd1 : 16'd0);
    end
  endtask

  task automatic test_directed();
    send(MODE_FREE, 10'd0, 16'd1);
    send(MODE_LOOKUP, 10'd0, 16'd0);
    send(MODE_CHECK, 10'd1023, 16'hFFFF);
    send(MODE_ALLOC, 10'h3FF, 16'hFFFF);
    send(MODE_ALLOC, 10'd0, 16'd0);
    send(MODE_ALLOC, 10'd0, 16'd0);
    send(MODE_CHECK, 10'd0, 16'd1);
    send(MODE_CHECK, 10'd0, 16'd0);
    send(MODE_LOOKUP, 10'd2, 16'd1);
    send(MODE_MARK, 10'd1, 16'd1);
    send(MODE_MARK, 10'd1, 16'd2);
    send(MODE_FREE, 10'd0, 16'd1);
    send(MODE_FREE, 10'd0, 16'd1);
    send(MODE_CHECK, 10'd0, 16'd1);
    send(MODE_LOOKUP, 10'd2, 16'd1);
    send(3'd5, 10'd2, 16'd1);
    send(3'd6, 10'h3FF, 16'hFFFF);
    send(3'd7, 10'd0, 16'd0);
    send(MODE_ALLOC, 10'd0, 16'd0);
    send(MODE_FREE, 10'd2, 16'd1);
  endtask

  task automatic test_wrap();
    logic [9:0] s;
    for (int i = 0; i < 10; i++) begin
      send(MODE_ALLOC, 10'd0, 16'd0);
      s = dslot_m[count_m - 11'd1];
      send(MODE_FREE, s, gen_m[s]);
    end
  endtask

  task automatic test_random();
    logic [9:0] s;
    logic [15:0] g;
    logic [2:0] mode;
    int k;
    for (int i = 0; i < 400; i++) begin
      calm = (i >= 150 && i < 250);
      k = $urandom_range(99);
      if (k < 30) mode = MODE_ALLOC;
      else if (k < 55) mode = MODE_FREE;
      else if (k < 70) mode = MODE_CHECK;
      else if (k < 82) mode = MODE_MARK;
      else if (k < 97) mode = MODE_LOOKUP;
      else mode = 3'($urandom_range(7, 5));
      pick_handle(s, g);
      send(mode, s, g);
    end
    calm = 1'b0;
  endtask

  initial begin
    int waited;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.slot = '0;
    in_ch.generation = '0;
    for (int i = 0; i < NSLOT; i++) begin
      link_m[i] = 11'(i + 1);
      gen_m[i] = '0;
      live_m[i] = 1'b0;
      dslot_m[i] = '0;
      dirty_m[i] = 1'b0;
    end
    head_m = '0;
    count_m = '0;
    serial_m = 32'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_wrap();
    test_random();
    in_ch.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire
